### rtl/assert_macros.svh
// assertion macros shared by the peer table rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds at an edge implies b at the same edge
`define ASSERT_IMPLY(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("implication check failed");

// a holds at an edge implies b at the next edge
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

### rtl/ptbl_pkg.sv
// types and constants of the peer table
// no dependencies
package ptbl_pkg;

    localparam logic [39:0] MAGIC_VALUE    = 40'h4E414C4450;
    localparam logic [7:0]  FORMAT_VERSION = 8'h01;
    localparam int          FLAG_GOODBYE   = 0;
    localparam int          FLAG_OFFLINE   = 1;

    localparam logic [1:0] OP_DATAGRAM = 2'd0;
    localparam logic [1:0] OP_LOOKUP   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_REMOVED   = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_OWN       = 3'd3;
    localparam logic [2:0] ST_BLOCKED   = 3'd4;
    localparam logic [2:0] ST_OFFLINE   = 3'd5;
    localparam logic [2:0] ST_PROTO     = 3'd6;
    localparam logic [2:0] ST_ZERO      = 3'd7;

    localparam logic [2:0] REG_OWN_HANDLE   = 3'd0;
    localparam logic [2:0] REG_PROTOCOL     = 3'd1;
    localparam logic [2:0] REG_OFFLINE      = 3'd2;
    localparam logic [2:0] REG_TTL          = 3'd3;
    localparam logic [2:0] REG_INTERVAL     = 3'd4;

    localparam int IN_W  = 240;
    localparam int OUT_W = 56;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_REMOVE,
        KIND_RECORD,
        KIND_LOOKUP,
        KIND_PRUNE
    } scan_kind_t;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] address;
        logic [15:0] port;
        logic [31:0] seen;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic wr_en;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic need_write;
    } dp_status_t;

endpackage

### rtl/ptbl_ctrl.sv
// sequencer for the peer table: item handshake, scan count, output valid
// depends on ptbl_pkg and assert_macros.svh
`include "assert_macros.svh"
module ptbl_ctrl
    import ptbl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int CNT_W = 7,
    parameter int IDX_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  dp_status_t       status,
    output dp_cmd_t          cmd,
    output logic [IDX_W-1:0] rd_addr
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_DONE} state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             m_tvalid_reg;
    logic             out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_addr  = cnt_reg[IDX_W-1:0];

    always_comb begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && s_tvalid;
        cmd.rd_en    = (state_reg == S_SCAN) && (cnt_reg < CNT_W'(TABLE_ENTRIES));
        cmd.wr_en    = (state_reg == S_WRITE);
        cmd.load_out = (state_reg == S_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // output valid: set on load, dropped once taken
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    cnt_reg <= '0;
                    if (s_tvalid) begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // first cycle after capture: skip straight out if no scan; else count up, leave at table end
                    if (!status.need_scan || cnt_reg == CNT_W'(TABLE_ENTRIES)) begin
                        state_reg <= status.need_write ? S_WRITE : S_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_WRITE: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_capture_leaves_idle, aclk, aresetn, s_tvalid && s_tready, state_reg == S_SCAN)
    `ASSERT_IMPLY(a_write_after_scan, aclk, aresetn, cmd.wr_en, status.need_write)
    `ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, cmd.load_out, m_tvalid_reg)

endmodule

### rtl/ptbl_datapath.sv
// peer table datapath: config registers, filters, entry memory, scan logic
// depends on ptbl_pkg and assert_macros.svh
`include "assert_macros.svh"
module ptbl_datapath
    import ptbl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int IDX_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic [1:0]       in_opcode,
    input  logic [IN_W-1:0]  in_data,
    input  dp_cmd_t          cmd,
    input  logic [IDX_W-1:0] rd_addr,
    output dp_status_t       status,
    output logic [OUT_W-1:0] out_data
);

    logic [31:0] own_handle_reg;
    logic [15:0] protocol_reg;
    logic        offline_reg;
    logic [15:0] ttl_reg;
    logic [15:0] interval_reg;
    logic [31:0] last_announce_reg;

    logic [31:0] in_now, in_handle, in_laddr, in_saddr;
    logic [39:0] in_magic;
    logic [7:0]  in_ver, in_flags;
    logic [15:0] in_lport, in_proto, in_sport;
    logic        in_blocked;

    assign in_now     = in_data[31:0];
    assign in_magic   = in_data[71:32];
    assign in_ver     = in_data[79:72];
    assign in_flags   = in_data[87:80];
    assign in_handle  = in_data[119:88];
    assign in_laddr   = in_data[151:120];
    assign in_lport   = in_data[167:152];
    assign in_proto   = in_data[183:168];
    assign in_saddr   = in_data[215:184];
    assign in_sport   = in_data[231:216];
    assign in_blocked = in_data[232];

    scan_kind_t  kind_reg;
    logic [2:0]  stat_reg;
    logic        due_reg;
    logic        offl_reg;
    logic [31:0] now_reg;
    logic [31:0] handle_reg;
    logic [31:0] addr_reg;
    logic [15:0] port_reg;

    // filter chain and tick decision
    scan_kind_t  kind_next;
    logic [2:0]  stat_next;
    logic        due_next;
    logic [31:0] since_last;

    assign since_last = in_now - last_announce_reg;

    always_comb begin
        kind_next = KIND_NONE;
        stat_next = ST_OK;
        due_next  = 1'b0;
        case (in_opcode)
            OP_DATAGRAM: begin
                if (in_magic != MAGIC_VALUE || in_ver != FORMAT_VERSION) begin
                    stat_next = ST_BAD_MAGIC;
                end else if (in_handle == own_handle_reg) begin
                    stat_next = ST_OWN;
                end else if (in_blocked) begin
                    stat_next = ST_BLOCKED;
                end else if (in_flags[FLAG_OFFLINE]) begin
                    stat_next = ST_OFFLINE;
                end else if (in_flags[FLAG_GOODBYE]) begin
                    stat_next = ST_REMOVED;
                    kind_next = KIND_REMOVE;
                end else if (in_proto != protocol_reg) begin
                    stat_next = ST_PROTO;
                end else if (in_handle == '0) begin
                    stat_next = ST_ZERO;
                end else begin
                    kind_next = KIND_RECORD;
                end
            end
            OP_LOOKUP: begin
                if (in_handle == '0) begin
                    stat_next = ST_ZERO;
                end else begin
                    kind_next = KIND_LOOKUP;
                end
            end
            OP_TICK: begin
                kind_next = KIND_PRUNE;
                due_next  = (last_announce_reg == '0) ||
                            (since_last >= {16'd0, interval_reg});
            end
            default: begin
                kind_next = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_handle_reg    <= '0;
            protocol_reg      <= '0;
            offline_reg       <= 1'b0;
            ttl_reg           <= 16'd15000;
            interval_reg      <= 16'd3000;
            last_announce_reg <= '0;
            kind_reg          <= KIND_NONE;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_OWN_HANDLE: own_handle_reg <= cfg_data;
                    REG_PROTOCOL:   protocol_reg   <= cfg_data[15:0];
                    REG_OFFLINE:    offline_reg    <= cfg_data[0];
                    REG_TTL:        ttl_reg        <= cfg_data[15:0];
                    REG_INTERVAL:   interval_reg   <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.capture) begin
                kind_reg <= kind_next;
                if (due_next) begin
                    last_announce_reg <= in_now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            stat_reg   <= stat_next;
            due_reg    <= due_next;
            offl_reg   <= due_next & offline_reg;
            now_reg    <= in_now;
            handle_reg <= in_handle;
            addr_reg   <= (in_laddr != '0) ? in_laddr : in_saddr;
            port_reg   <= (in_lport != '0) ? in_lport : in_sport;
        end
    end

    assign status.need_scan  = (kind_reg != KIND_NONE);
    assign status.need_write = (kind_reg == KIND_RECORD);

    // entry memory with registered read, valid bits in flops
    entry_t           mem [TABLE_ENTRIES];
    entry_t           rd_data;
    logic             valid_reg [TABLE_ENTRIES];
    logic             proc_en_reg;
    logic [IDX_W-1:0] proc_idx_reg;

    // scan accumulators
    logic             hit_reg;
    logic [IDX_W-1:0] hit_slot_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_slot_reg;
    logic [IDX_W-1:0] old_slot_reg;
    logic [31:0]      old_seen_reg;
    logic [31:0]      found_addr_reg;
    logic [15:0]      found_port_reg;

    logic             pv, match, expired, clear_valid;
    logic [IDX_W-1:0] wr_slot;
    logic [31:0]      age;

    assign pv      = valid_reg[proc_idx_reg];
    assign age     = now_reg - rd_data.seen;
    assign expired = pv && (age > {16'd0, ttl_reg});
    assign match   = pv && (rd_data.handle == handle_reg);
    assign wr_slot = hit_reg ? hit_slot_reg : (free_reg ? free_slot_reg : old_slot_reg);

    always_comb begin
        clear_valid = 1'b0;
        case (kind_reg)
            KIND_REMOVE: clear_valid = match && !hit_reg;
            KIND_LOOKUP: clear_valid = expired;
            KIND_PRUNE:  clear_valid = expired;
            default:     clear_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (cmd.wr_en) begin
            mem[wr_slot] <= '{handle: handle_reg, address: addr_reg,
                              port: port_reg, seen: now_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
            proc_en_reg <= 1'b0;
        end else begin
            proc_en_reg <= cmd.rd_en;
            if (proc_en_reg && clear_valid) begin
                valid_reg[proc_idx_reg] <= 1'b0;
            end
            if (cmd.wr_en) begin
                valid_reg[wr_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        proc_idx_reg <= rd_addr;
        if (cmd.capture) begin
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            found_addr_reg <= '0;
            found_port_reg <= '0;
        end else if (proc_en_reg) begin
            // lookups skip expired entries, datagrams match them as stored
            if (match && !hit_reg && !(kind_reg == KIND_LOOKUP && expired)) begin
                hit_reg      <= 1'b1;
                hit_slot_reg <= proc_idx_reg;
                if (kind_reg == KIND_LOOKUP) begin
                    found_addr_reg <= rd_data.address;
                    found_port_reg <= rd_data.port;
                end
            end
            if (!pv && !free_reg) begin
                free_reg      <= 1'b1;
                free_slot_reg <= proc_idx_reg;
            end
            // oldest seen time, lowest index wins a tie
            if (proc_idx_reg == '0 || rd_data.seen < old_seen_reg) begin
                old_seen_reg <= rd_data.seen;
                old_slot_reg <= proc_idx_reg;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data <= {2'b00, offl_reg, due_reg, found_port_reg, found_addr_reg,
                         (kind_reg == KIND_LOOKUP) && hit_reg, stat_reg};
        end
    end

    `ASSERT_IMPLY(a_write_only_record, aclk, aresetn, cmd.wr_en, kind_reg == KIND_RECORD)
    `ASSERT_IMPLY(a_no_scan_on_capture, aclk, aresetn, cmd.capture, !cmd.rd_en && !proc_en_reg)

endmodule

### rtl/peer_table_with_ttl_and_oldest_eviction.sv
// peer table keyed by handle, with ttl pruning and oldest-entry eviction
// accept to result for a record: capture, one memory read per entry plus a drain step,
// write, output load; a lookup, tick or goodbye skips the write, and an item that the
// filters settle skips the scan as well; the entry scan sets the rate
// the next item is accepted in the cycle the result appears, while it waits downstream
// reset (aresetn low, synchronous) clears valid bits, config to defaults, last announce
// depends on ptbl_pkg, ptbl_ctrl, ptbl_datapath
module peer_table_with_ttl_and_oldest_eviction
    import ptbl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    // fields: now_ms, magic_bytes, packet_version, packet_flags, sender_handle,
    // listen_address, announced_port, peer_protocol, source_address, source_port,
    // sender_blocked
    input  logic [IN_W-1:0]   s_tdata,
    // fields: opcode
    input  logic [1:0]        s_tuser,
    input  logic              s_tvalid,
    output logic              s_tready,
    // fields: status, found, found_address, found_port, announce_due,
    // announce_offline
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // config write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    // index and counter widths follow from table depth
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1) + 1;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [IDX_W-1:0] rd_addr;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    // controller: handshakes and scan sequencing
    ptbl_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CNT_W         (CNT_W),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    // datapath: filters, entry memory, scan accumulators, result register
    ptbl_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_opcode (s_tuser),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .status    (status),
        .out_data  (m_tdata)
    );

endmodule

### verif/testbench.sv
// self-checking testbench of the peer table: directed table, then random traffic
// depends on ptbl_pkg and peer_table_with_ttl_and_oldest_eviction
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ptbl_pkg::*;

    localparam int ENTRIES = 64;
    localparam int PHASE_ITEMS = 100;
    localparam int CYCLE_LIMIT = 2000000;

    // input fields, lowest field last so that it lands in the low bits
    typedef struct packed {
        logic        blocked;
        logic [15:0] sport;
        logic [31:0] saddr;
        logic [15:0] proto;
        logic [15:0] lport;
        logic [31:0] laddr;
        logic [31:0] handle;
        logic [7:0]  flags;
        logic [7:0]  ver;
        logic [39:0] magic;
        logic [31:0] now;
    } fields_t;

    typedef struct packed {
        logic        offl;
        logic        due;
        logic [15:0] port;
        logic [31:0] addr;
        logic        found;
        logic [2:0]  status;
    } result_t;

    typedef struct {
        logic [1:0] op;
        fields_t    f;
        bit         lit;
        result_t    r;
    } row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic [IN_W-1:0]   s_tdata = '0;
    logic [1:0]        s_tuser = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [31:0]       cfg_data = '0;

    peer_table_with_ttl_and_oldest_eviction i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    // predictor copy of configuration and table
    logic [31:0] own_handle_q = '0;
    logic [15:0] proto_q = '0;
    logic        offline_q = 1'b0;
    logic [15:0] ttl_q = 16'd15000;
    logic [15:0] interval_q = 16'd3000;
    logic        tbl_valid [ENTRIES];
    logic [31:0] tbl_handle [ENTRIES];
    logic [31:0] tbl_addr [ENTRIES];
    logic [15:0] tbl_port [ENTRIES];
    logic [31:0] tbl_seen [ENTRIES];
    logic [31:0] last_announce = '0;

    result_t pending_results[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_req = 0;
    logic [31:0] clock_ms = 32'd5;

    initial begin
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    end

    function automatic int find_peer(logic [31:0] h);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_handle[i] == h) return i;
        return -1;
    endfunction

    function automatic void prune_table(logic [31:0] now);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && (now - tbl_seen[i]) > {16'd0, ttl_q}) tbl_valid[i] = 1'b0;
    endfunction

    // expected result of one item, updating the table copy
    function automatic result_t peer_table_step(logic [1:0] op, fields_t f);
        result_t r;
        int idx;
        r = '0;
        case (op)
            OP_DATAGRAM: begin
                if (f.magic != MAGIC_VALUE || f.ver != FORMAT_VERSION) r.status = ST_BAD_MAGIC;
                else if (f.handle == own_handle_q) r.status = ST_OWN;
                else if (f.blocked) r.status = ST_BLOCKED;
                else if (f.flags[FLAG_OFFLINE]) r.status = ST_OFFLINE;
                else if (f.flags[FLAG_GOODBYE]) begin
                    idx = find_peer(f.handle);
                    if (idx >= 0) tbl_valid[idx] = 1'b0;
                    r.status = ST_REMOVED;
                end else if (f.proto != proto_q) r.status = ST_PROTO;
                else if (f.handle == 32'd0) r.status = ST_ZERO;
                else begin
                    // update match, else lowest free slot, else oldest seen time
                    idx = find_peer(f.handle);
                    if (idx < 0)
                        for (int i = 0; i < ENTRIES; i++)
                            if (!tbl_valid[i]) begin
                                idx = i;
                                break;
                            end
                    if (idx < 0) begin
                        idx = 0;
                        for (int i = 1; i < ENTRIES; i++)
                            if (tbl_seen[i] < tbl_seen[idx]) idx = i;
                    end
                    tbl_valid[idx] = 1'b1;
                    tbl_handle[idx] = f.handle;
                    tbl_addr[idx] = (f.laddr != 0) ? f.laddr : f.saddr;
                    tbl_port[idx] = (f.lport != 0) ? f.lport : f.sport;
                    tbl_seen[idx] = f.now;
                    r.status = ST_OK;
                end
            end
            OP_LOOKUP: begin
                if (f.handle == 32'd0) r.status = ST_ZERO;
                else begin
                    prune_table(f.now);
                    idx = find_peer(f.handle);
                    if (idx >= 0) begin
                        r.found = 1'b1;
                        r.addr = tbl_addr[idx];
                        r.port = tbl_port[idx];
                    end
                end
            end
            OP_TICK: begin
                if (last_announce == 0 || (f.now - last_announce) >= {16'd0, interval_q}) begin
                    last_announce = f.now;
                    r.due = 1'b1;
                    r.offl = offline_q;
                end
                prune_table(f.now);
            end
            default: ;
        endcase
        return r;
    endfunction

    // well-formed announcement from handle h at time now
    function automatic fields_t announce_fields(logic [31:0] now, logic [31:0] h);
        fields_t f;
        f = '0;
        f.now = now;
        f.magic = MAGIC_VALUE;
        f.ver = FORMAT_VERSION;
        f.handle = h;
        f.proto = proto_q;
        f.saddr = 32'h0a000001 + h;
        f.sport = 16'd4000;
        f.laddr = $urandom_range(3) == 0 ? 32'd0 : $urandom;
        f.lport = $urandom_range(3) == 0 ? 16'd0 : 16'($urandom);
        return f;
    endfunction

    function automatic logic [31:0] pick_handle();
        case ($urandom_range(19))
            0: return 32'd0;
            1: return own_handle_q;
            2: return $urandom;
            default: return $urandom_range(1, 90);
        endcase
    endfunction

    // drive one item; entered and left at a falling edge
    task automatic send_item(logic [1:0] op, fields_t f, bit lit, result_t lr);
        int gap;
        result_t r;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 200) gap++;
        repeat (gap) @(negedge aclk);
        s_tdata = {{(IN_W - $bits(fields_t)){1'b0}}, f};
        s_tuser = op;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = peer_table_step(op, f);
        if (lit) r = lr;
        pending_results.push_back(r);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // register write once the block has drained
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_OWN_HANDLE: own_handle_q = value;
            REG_PROTOCOL:   proto_q = value[15:0];
            REG_OFFLINE:    offline_q = value[0];
            REG_TTL:        ttl_q = value[15:0];
            REG_INTERVAL:   interval_q = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // receiver: random stalls per phase, one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_tready = 1'b0;
                repeat (3000) @(negedge aclk);
            end else m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker against the oldest expectation
    always @(posedge aclk) begin
        result_t act, exp_r;
        logic [31:0] ev [6];
        logic [31:0] av [6];
        string names [6];
        if (aresetn && m_tvalid && m_tready) begin
            act = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, act);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                names = '{"status", "found", "found_address", "found_port",
                          "announce_due", "announce_offline"};
                ev = '{exp_r.status, exp_r.found, exp_r.addr, exp_r.port, exp_r.due, exp_r.offl};
                av = '{act.status, act.found, act.addr, act.port, act.due, act.offl};
                for (int i = 0; i < 6; i++)
                    if (ev[i] !== av[i]) begin
                        $display("%0t: %s expected %h actual %h", $time, names[i], ev[i], av[i]);
                        errors++;
                    end
            end
        end
    end

    // cycle limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    initial begin
        row_t rows[$];
        row_t row;
        fields_t f;
        logic [1:0] op;
        int sel;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed table; literal results where they are obvious
        row = '{OP_TICK, '0, 1, '0};
        row.f.now = 32'd100;
        row.r.due = 1'b1;
        rows.push_back(row);
        row = '{OP_DATAGRAM, announce_fields(200, 5), 1, '0};
        row.f.magic = ~MAGIC_VALUE;
        row.r.status = ST_BAD_MAGIC;
        rows.push_back(row);
        row = '{OP_DATAGRAM, announce_fields(200, 5), 1, '0};
        row.f.ver = 8'hff;
        row.r.status = ST_BAD_MAGIC;
        rows.push_back(row);
        row = '{OP_DATAGRAM, announce_fields(200, 0), 1, '0};
        row.r.status = ST_OWN;                          // own handle is zero after reset
        rows.push_back(row);
        row = '{OP_DATAGRAM, announce_fields(200, 5), 1, '0};
        row.f.blocked = 1'b1;
        row.r.status = ST_BLOCKED;
        rows.push_back(row);
        row = '{OP_DATAGRAM, announce_fields(200, 5), 1, '0};
        row.f.flags = 8'hff;                            // offline wins over goodbye
        row.r.status = ST_OFFLINE;
        rows.push_back(row);
        row = '{OP_DATAGRAM, announce_fields(200, 5), 1, '0};
        row.f.flags = 8'h01;                            // goodbye of an absent peer
        row.r.status = ST_REMOVED;
        rows.push_back(row);
        row = '{OP_DATAGRAM, announce_fields(200, 5), 1, '0};
        row.f.proto = 16'hffff;
        row.r.status = ST_PROTO;
        rows.push_back(row);
        row = '{OP_DATAGRAM, announce_fields(300, 32'hffffffff), 0, '0};
        row.f.laddr = '0;                               // falls back to source endpoint
        row.f.lport = '0;
        row.f.saddr = 32'hffffffff;
        row.f.sport = 16'hffff;
        rows.push_back(row);
        row = '{OP_DATAGRAM, announce_fields(300, 7), 0, '0};
        row.f.laddr = 32'hffffffff;
        row.f.lport = 16'hffff;
        rows.push_back(row);
        row = '{OP_LOOKUP, '0, 1, '0};
        row.r.status = ST_ZERO;
        rows.push_back(row);
        row = '{OP_LOOKUP, '0, 0, '0};
        row.f.now = 32'd400;
        row.f.handle = 32'd7;
        rows.push_back(row);
        row = '{OP_LOOKUP, '0, 0, '0};
        row.f.now = 32'd400;
        row.f.handle = 32'hffffffff;
        rows.push_back(row);
        row = '{OP_LOOKUP, '0, 1, '0};
        row.f.now = 32'd400;
        row.f.handle = 32'd99;
        rows.push_back(row);
        row = '{OP_TICK, '0, 1, '0};
        row.f.now = 32'd101;                            // interval not yet over
        rows.push_back(row);
        row = '{OP_TICK, '0, 1, '0};
        row.f.now = 32'hffffffff;
        row.r.due = 1'b1;
        rows.push_back(row);
        row = '{OP_LOOKUP, '0, 1, '0};
        row.f.now = 32'hffffffff;                       // everything expired by now
        row.f.handle = 32'd7;
        rows.push_back(row);
        row = '{2'd3, '1, 1, '0};                       // unused opcode
        rows.push_back(row);
        foreach (rows[i]) send_item(rows[i].op, rows[i].f, rows[i].lit, rows[i].r);

        // random phases, each with its own register setting and idling mode
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_OWN_HANDLE, 32'hffffffff);
                    write_reg(REG_PROTOCOL, 32'h0000ffff);
                    write_reg(REG_OFFLINE, 32'd1);
                    write_reg(REG_TTL, 32'd65535);
                    write_reg(REG_INTERVAL, 32'd0);
                end
                1: begin
                    write_reg(REG_OWN_HANDLE, 32'd0);
                    write_reg(REG_PROTOCOL, 32'd0);
                    write_reg(REG_OFFLINE, 32'd0);
                    write_reg(REG_TTL, 32'd0);
                    write_reg(REG_INTERVAL, 32'd65535);
                end
                default: begin
                    write_reg(REG_OWN_HANDLE, $urandom_range(1) ? $urandom_range(1, 90) : $urandom);
                    write_reg(REG_PROTOCOL, $urandom_range(3));
                    write_reg(REG_OFFLINE, $urandom_range(1));
                    write_reg(REG_TTL, $urandom_range(1) ? $urandom_range(500, 20000) : $urandom);
                    write_reg(REG_INTERVAL, $urandom_range(3000));
                end
            endcase
            // none, sender idle, receiver stalling, both lightly
            send_idle_pct = (phase % 4 == 1) ? 88 : ((phase % 4 == 3) ? 22 : 0);
            recv_stall_pct = (phase % 4 == 2) ? 88 : ((phase % 4 == 3) ? 22 : 0);
            // long hold-off so the block backs up onto its input
            if (phase == 2) hold_req = 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(99);
                if ($urandom_range(49) == 0) clock_ms = $urandom;
                else if ($urandom_range(3) != 0)
                    clock_ms += $urandom_range(0, (ttl_q >> 4) + 2);
                if (sel < 10) begin
                    // noise over every bit
                    op = 2'($urandom);
                    f = {1'($urandom), 40'($urandom), {$urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom}};
                end else if (sel < 60) begin
                    op = OP_DATAGRAM;
                    f = announce_fields(clock_ms, pick_handle());
                    case ($urandom_range(19))
                        0: f.magic[$urandom_range(39)] ^= 1'b1;
                        1: f.ver = 8'($urandom);
                        2: f.blocked = 1'b1;
                        3, 4, 5: f.flags = 8'($urandom);
                        6, 7: f.flags = 8'h01;
                        8: f.proto = 16'($urandom);
                        default: ;
                    endcase
                end else if (sel < 88) begin
                    op = OP_LOOKUP;
                    f = '0;
                    f.now = clock_ms;
                    f.handle = pick_handle();
                end else begin
                    op = OP_TICK;
                    f = '0;
                    f.now = clock_ms;
                end
                send_item(op, f, 0, '0);
            end
        end

        while (pending_results.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
